// ===== design/lbw_pkg.sv =====
`timescale 1ns / 1ps
package lbw_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_LFO_STEP    = 3'd0;
   localparam logic [2:0] CSR_START_PHASE = 3'd1;
   localparam logic [2:0] CSR_SWEEP_DEPTH = 3'd2;
   localparam logic [2:0] CSR_FREQ_OFFSET = 3'd3;
   localparam logic [2:0] CSR_RESONANCE   = 3'd4;

   localparam int DEF_UPDATE_INTERVAL = 30;
   localparam int DEF_SAMPLE_WIDTH    = 24;

   localparam logic [23:0] RST_LFO_STEP    = 24'd146088;
   localparam logic [15:0] RST_START_PHASE = 16'd32768;
   localparam logic [15:0] RST_SWEEP_DEPTH = 16'd22938;
   localparam logic [15:0] RST_FREQ_OFFSET = 16'd9830;
   localparam logic [11:0] RST_RESONANCE   = 12'd640;

   localparam logic [31:0] QUARTER_TURN  = 32'h4000_0000;
   localparam logic [31:0] ONE_Q30       = 32'h4000_0000;
   localparam logic [15:0] UNIT_Q15      = 16'h8000;
   localparam logic [31:0] SIX_LOG2E_Q24 = 32'd145226438;
   localparam logic [31:0] LN2_Q30       = 32'd744261118;
   localparam logic signed [31:0] SIN_C9 = 32'sd172272;
   localparam logic [11:0] RES_FLOOR     = 12'd26;

   // Configuration registers as seen by the sequencer.
   typedef struct packed {
      logic [23:0] lfo_step;
      logic [15:0] start_phase;
      logic [15:0] sweep_depth;
      logic [15:0] freq_offset;
      logic [11:0] resonance;
   } lbw_cfg_type;

   // Horner coefficients of the sine polynomial after the top term.
   function automatic logic signed [31:0] sin_coef(input logic [1:0] k);
      logic signed [31:0] c;
      case (k)
         2'd0: c = -32'sd5026995;
         2'd1: c = 32'sd85569306;
         2'd2: c = -32'sd693598668;
         2'd3: c = 32'sd1686629713;
         default: c = 32'sd0;
      endcase
      return c;
   endfunction

   // Product divided by 2^30, truncated toward zero.
   function automatic logic signed [63:0] q30_trunc(input logic signed [63:0] v);
      logic signed [63:0] b;
      b = v[63] ? 64'sd1073741823 : 64'sd0;
      return (v + b) >>> 30;
   endfunction

endpackage

// ===== design/lbw_mul.sv =====
`timescale 1ns / 1ps
module lbw_mul import lbw_pkg::*; (
   input  logic               clock,
   input  logic signed [31:0] mul_a,
   input  logic signed [31:0] mul_b,
   output logic signed [63:0] prod_ff
);

   // Registered signed product, ready in the cycle after the operands.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

// ===== design/lbw_div.sv =====
`timescale 1ns / 1ps
module lbw_div import lbw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] numer,
   input  logic        [33:0] denom,
   output logic               done_ff,
   output logic signed [63:0] quot
);

   logic        busy_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] mag_ff;
   logic [33:0] rem_ff;
   logic [33:0] den_ff;
   logic        neg_ff;
   logic [34:0] rem_sh;
   logic        fits;

   // One quotient bit per cycle, restoring.
   assign rem_sh = {rem_ff, mag_ff[63]};
   assign fits   = rem_sh >= {1'b0, den_ff};
   assign quot   = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Magnitude register shifts the dividend out and the quotient in.
   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= numer[63] ? 64'(-numer) : 64'(numer);
         neg_ff <= numer[63];
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[62:0], fits};
         rem_ff <= fits ? 34'(rem_sh - {1'b0, den_ff}) : rem_sh[33:0];
      end
   end

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff)) else $error("divider done out of turn");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done longer than a cycle");
`endif

endmodule

// ===== design/lbw_seq.sv =====
`timescale 1ns / 1ps
module lbw_seq import lbw_pkg::*; #(
   parameter int UPDATE_INTERVAL = DEF_UPDATE_INTERVAL,
   parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lbw_cfg_type                    cfg,
   input  logic                           start,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic                           out_busy,
   output logic                           idle,
   output logic                           done,
   output logic signed [SAMPLE_WIDTH-1:0] res,
   output logic                           clip
);

   localparam int CNT_W = (UPDATE_INTERVAL > 1) ? $clog2(UPDATE_INTERVAL) : 1;

   localparam logic [4:0] ST_IDLE = 5'd0,  ST_ANGLE = 5'd1,  ST_SIN_T = 5'd2,
                          ST_SIN_M = 5'd3, ST_SIN_W = 5'd4,  ST_SIN_PM = 5'd5,
                          ST_SIN_PA = 5'd6, ST_SIN_S = 5'd7, ST_SIN_SW = 5'd8,
                          ST_F0 = 5'd9,    ST_F1 = 5'd10,    ST_F2 = 5'd11,
                          ST_F3 = 5'd12,   ST_F4 = 5'd13,    ST_U1 = 5'd14,
                          ST_U2 = 5'd15,   ST_Z1 = 5'd16,    ST_Z2 = 5'd17,
                          ST_E1 = 5'd18,   ST_E2 = 5'd19,    ST_E3 = 5'd20,
                          ST_E4 = 5'd21,   ST_D = 5'd22,     ST_DW = 5'd23,
                          ST_C = 5'd24,    ST_CW = 5'd25,    ST_FM = 5'd26,
                          ST_FA = 5'd27,   ST_FY = 5'd28;

   logic [4:0]                     state_ff;
   logic [31:0]                    angle_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, xh1_ff, xh2_ff;
   logic signed [31:0]             yh1_ff, yh2_ff;
   logic signed [31:0]             coef_ff [5];
   logic [31:0]                    arg_ff;
   logic signed [31:0]             t_ff, t2_ff, p_ff, c_ff, sn_ff, cs_ff;
   logic [3:0]                     k_ff;
   logic [1:0]                     sel_ff;
   logic [31:0]                    f_ff, z_ff;
   logic [34:0]                    u_ff;
   logic [33:0]                    damp_ff;
   logic [2:0]                     ci_ff, fi_ff;
   logic signed [63:0]             acc_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff;
   logic               div_start, div_done;
   logic signed [63:0] div_num, div_quot;
   logic [33:0]        div_den;

   logic [CNT_W:0]     cnt_inc;
   logic [CNT_W-1:0]   cnt_in;
   logic [15:0]        dep, ofs, res_q;
   logic signed [63:0] sin_raw, omc, y_div, y_sat;
   logic signed [31:0] sin_val, y32;
   logic signed [32:0] f_sum;
   logic [32:0]        f_new;
   logic [4:0]         whole;
   logic [31:0]        e_val;
   logic signed [63:0] hi_lim, lo_lim;

   lbw_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .prod_ff(prod_ff));

   lbw_div u_div (.clock(clock), .reset(reset), .start(div_start), .numer(div_num),
                  .denom(div_den), .done_ff(div_done), .quot(div_quot));

   // Update counter wraps at the interval.
   assign cnt_inc = {1'b0, cnt_ff} + (CNT_W+1)'(1);
   assign cnt_in  = (cnt_inc >= (CNT_W+1)'(UPDATE_INTERVAL)) ? '0 : cnt_inc[CNT_W-1:0];

   // Clamped configuration values.
   assign dep   = (cfg.sweep_depth > UNIT_Q15) ? UNIT_Q15 : cfg.sweep_depth;
   assign ofs   = (cfg.freq_offset > UNIT_Q15) ? UNIT_Q15 : cfg.freq_offset;
   assign res_q = {4'd0, (cfg.resonance < RES_FLOOR) ? RES_FLOOR : cfg.resonance};

   // Sine result clamped to the unit range and given the quadrant sign.
   always_comb begin
      sin_raw = q30_trunc(prod_ff);
      if (sin_raw < 0) begin
         sin_val = 32'sd0;
      end else if (sin_raw > 64'sd1073741824) begin
         sin_val = 32'sd1073741824;
      end else begin
         sin_val = sin_raw[31:0];
      end
      if (arg_ff[31]) begin
         sin_val = -sin_val;
      end
   end

   assign f_sum = 33'(c_ff) + 33'sd1073741824;
   assign f_new = 33'(prod_ff[46:15]) + {2'd0, ofs, 15'd0};
   assign whole = u_ff[34:30];
   assign e_val = (whole >= 5'd31) ? 32'd0 : (p_ff >> whole);
   assign omc   = 64'sd1073741824 - 64'(cs_ff);

   // Filter output: truncate toward zero, then saturate to 32 and sample bits.
   assign hi_lim = 64'sd2 ** (SAMPLE_WIDTH - 1) - 64'sd1;
   assign lo_lim = -(64'sd2 ** (SAMPLE_WIDTH - 1));
   always_comb begin
      y_div = (acc_ff + (acc_ff[63] ? 64'sd268435455 : 64'sd0)) >>> 28;
      if (y_div > 64'sd2147483647) begin
         y_sat = 64'sd2147483647;
      end else if (y_div < -64'sd2147483648) begin
         y_sat = -64'sd2147483648;
      end else begin
         y_sat = y_div;
      end
      y32 = y_sat[31:0];
      clip = 1'b1;
      if (y_sat > hi_lim) begin
         res = hi_lim[SAMPLE_WIDTH-1:0];
      end else if (y_sat < lo_lim) begin
         res = lo_lim[SAMPLE_WIDTH-1:0];
      end else begin
         res  = y_sat[SAMPLE_WIDTH-1:0];
         clip = 1'b0;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = 32'sd0;
      mul_b = 32'sd0;
      case (state_ff)
         ST_SIN_M: begin
            mul_a = t_ff; mul_b = t_ff;
         end
         ST_SIN_PM: begin
            mul_a = p_ff; mul_b = t2_ff;
         end
         ST_SIN_S: begin
            mul_a = p_ff; mul_b = t_ff;
         end
         ST_F1: begin
            mul_a = f_ff; mul_b = {16'd0, dep};
         end
         ST_F3: begin
            mul_a = f_ff; mul_b = {16'd0, UNIT_Q15 - ofs};
         end
         ST_U1: begin
            mul_a = ONE_Q30 - f_ff; mul_b = SIX_LOG2E_Q24;
         end
         ST_Z1: begin
            mul_a = {2'd0, u_ff[29:0]}; mul_b = LN2_Q30;
         end
         ST_E1: begin
            mul_a = z_ff; mul_b = p_ff;
         end
         ST_FM: begin
            mul_a = coef_ff[fi_ff];
            case (fi_ff)
               3'd0: mul_b = 32'(x_ff);
               3'd1: mul_b = 32'(xh1_ff);
               3'd2: mul_b = 32'(xh2_ff);
               3'd3: mul_b = yh1_ff;
               default: mul_b = yh2_ff;
            endcase
         end
         default: begin
            mul_a = 32'sd0;
         end
      endcase
   end

   // Divider requests: exp series terms, damping, then the coefficients.
   always_comb begin
      div_start = 1'b0;
      div_num   = 64'sd0;
      div_den   = damp_ff + 34'(ONE_Q30);
      case (state_ff)
         ST_E2: begin
            div_start = 1'b1;
            div_num   = prod_ff >>> 30;
            div_den   = {30'd0, k_ff};
         end
         ST_D: begin
            div_start = 1'b1;
            div_num   = 64'(sn_ff) <<< 7;
            div_den   = {18'd0, res_q};
         end
         ST_C: begin
            div_start = 1'b1;
            case (ci_ff)
               3'd0: div_num = omc <<< 27;
               3'd1: div_num = omc <<< 28;
               3'd3: div_num = 64'(cs_ff) <<< 29;
               default: div_num = (64'sd1073741824 - 64'(damp_ff)) <<< 28;
            endcase
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   assign idle = (state_ff == ST_IDLE);
   assign done = (state_ff == ST_FY) && !out_busy;

   // Control state and history.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         angle_ff <= '0;
         cnt_ff   <= '0;
         xh1_ff   <= '0;
         xh2_ff   <= '0;
         yh1_ff   <= '0;
         yh2_ff   <= '0;
         for (int i = 0; i < 5; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  angle_ff <= angle_ff + {8'd0, cfg.lfo_step};
                  cnt_ff   <= cnt_in;
                  state_ff <= (cnt_ff == '0) ? ST_ANGLE : ST_FM;
               end
            end
            ST_ANGLE:  state_ff <= ST_SIN_T;
            ST_SIN_T:  state_ff <= ST_SIN_M;
            ST_SIN_M:  state_ff <= ST_SIN_W;
            ST_SIN_W:  state_ff <= ST_SIN_PM;
            ST_SIN_PM: state_ff <= ST_SIN_PA;
            ST_SIN_PA: state_ff <= (k_ff == 4'd3) ? ST_SIN_S : ST_SIN_PM;
            ST_SIN_S:  state_ff <= ST_SIN_SW;
            ST_SIN_SW: begin
               case (sel_ff)
                  2'd0:    state_ff <= ST_F0;
                  2'd1:    state_ff <= ST_SIN_T;
                  default: state_ff <= ST_D;
               endcase
            end
            ST_F0: state_ff <= ST_F1;
            ST_F1: state_ff <= ST_F2;
            ST_F2: state_ff <= ST_F3;
            ST_F3: state_ff <= ST_F4;
            ST_F4: state_ff <= ST_U1;
            ST_U1: state_ff <= ST_U2;
            ST_U2: state_ff <= ST_Z1;
            ST_Z1: state_ff <= ST_Z2;
            ST_Z2: state_ff <= ST_E1;
            ST_E1: state_ff <= ST_E2;
            ST_E2: state_ff <= ST_E3;
            ST_E3: begin
               if (div_done) begin
                  state_ff <= (k_ff == 4'd1) ? ST_E4 : ST_E1;
               end
            end
            ST_E4: state_ff <= ST_SIN_T;
            ST_D:  state_ff <= ST_DW;
            ST_DW: begin
               if (div_done) begin
                  state_ff <= ST_C;
               end
            end
            ST_C: state_ff <= ST_CW;
            ST_CW: begin
               if (div_done) begin
                  coef_ff[ci_ff] <= (ci_ff == 3'd3) ? -div_quot[31:0] : div_quot[31:0];
                  if (ci_ff == 3'd4) begin
                     coef_ff[2] <= coef_ff[0];
                     state_ff   <= ST_FM;
                  end else begin
                     state_ff <= ST_C;
                  end
               end
            end
            ST_FM: state_ff <= ST_FA;
            ST_FA: state_ff <= (fi_ff == 3'd4) ? ST_FY : ST_FM;
            ST_FY: begin
               if (!out_busy) begin
                  xh2_ff   <= xh1_ff;
                  xh1_ff   <= x_ff;
                  yh2_ff   <= yh1_ff;
                  yh1_ff   <= y32;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Working registers of the coefficient and filter arithmetic.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            x_ff   <= sample;
            acc_ff <= '0;
            fi_ff  <= '0;
         end
         ST_ANGLE: begin
            arg_ff <= angle_ff + {cfg.start_phase, 16'd0} + QUARTER_TURN;
            sel_ff <= 2'd0;
         end
         ST_SIN_T: begin
            t_ff <= arg_ff[30] ? $signed(ONE_Q30 - {2'd0, arg_ff[29:0]})
                               : $signed({2'd0, arg_ff[29:0]});
         end
         ST_SIN_W: begin
            t2_ff <= sin_raw[31:0];
            p_ff  <= SIN_C9;
            k_ff  <= '0;
         end
         ST_SIN_PA: begin
            p_ff <= sin_coef(k_ff[1:0]) + sin_raw[31:0];
            k_ff <= k_ff + 4'd1;
         end
         ST_SIN_SW: begin
            case (sel_ff)
               2'd0: c_ff <= sin_val;
               2'd1: begin
                  sn_ff  <= sin_val[31] ? 32'sd0 : sin_val;
                  arg_ff <= arg_ff + QUARTER_TURN;
                  sel_ff <= 2'd2;
               end
               default: cs_ff <= sin_val;
            endcase
         end
         ST_F0: f_ff <= {1'b0, f_sum[31:1]};
         ST_F2: f_ff <= prod_ff[46:15];
         ST_F4: f_ff <= (f_new > 33'(ONE_Q30)) ? ONE_Q30 : f_new[31:0];
         ST_U2: u_ff <= prod_ff[58:24];
         ST_Z2: begin
            z_ff <= prod_ff[61:30];
            p_ff <= ONE_Q30;
            k_ff <= 4'd8;
         end
         ST_E3: begin
            if (div_done) begin
               p_ff <= ONE_Q30 - div_quot[31:0];
               k_ff <= k_ff - 4'd1;
            end
         end
         ST_E4: begin
            arg_ff <= {e_val[30:0], 1'b0};
            sel_ff <= 2'd1;
         end
         ST_DW: begin
            if (div_done) begin
               damp_ff <= div_quot[33:0];
               ci_ff   <= 3'd0;
            end
         end
         ST_CW: begin
            if (div_done) begin
               ci_ff <= (ci_ff == 3'd1) ? 3'd3 : ci_ff + 3'd1;
            end
         end
         ST_FA: begin
            acc_ff <= (fi_ff < 3'd3) ? acc_ff + prod_ff : acc_ff - prod_ff;
            fi_ff  <= fi_ff + 3'd1;
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_E3) || (state_ff == ST_DW) || (state_ff == ST_CW))
      else $error("divider result arrived outside a wait state");
   a_no_b2_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C) |-> (ci_ff != 3'd2)) else $error("b2 divided instead of copied");
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FA) |-> (fi_ff <= 3'd4)) else $error("filter tap out of range");
   a_exp_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_E2) |-> (k_ff >= 4'd1) && (k_ff <= 4'd8))
      else $error("series divisor out of range");
`endif

endmodule

// ===== design/lfo_swept_biquad_wah_filter.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Ports                                   Beat taken when
// req      in   req_valid, req_stall, req_sample_in     req_valid && !req_stall
// rsp      out  rsp_valid, rsp_stall, rsp_sample_out,   rsp_valid && !rsp_stall
//               rsp_clipped
// csr      in   csr_valid, csr_ready, csr_index,        csr_valid && csr_ready
//               csr_data
// Without a refresh a sample runs the five filter taps on the shared multiplier, each a
// multiply then an accumulate, then a hand-off state that waits for the output, then idle.
// On the first sample and every UPDATE_INTERVAL-th after, a coefficient refresh runs first,
// with the serial divider run 13 times (eight series terms, damping, four coefficients).
// One sample is in work at a time; the output register frees the core while it waits.
// Reset is synchronous and clears the LFO angle, counter, history and coefficients.
// A stalled result holds the next result in the core until it is taken.
module lfo_swept_biquad_wah_filter import lbw_pkg::*; #(
   parameter int UPDATE_INTERVAL = DEF_UPDATE_INTERVAL,
   parameter int SAMPLE_WIDTH    = DEF_SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   output logic                           rsp_clipped,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [2:0]                     csr_index,
   input  logic [23:0]                    csr_data
);

   lbw_cfg_type                    cfg_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                           rsp_clipped_ff;
   logic                           core_idle, core_done, core_clip;
   logic signed [SAMPLE_WIDTH-1:0] core_res;
   logic                           out_busy;

   assign csr_ready = 1'b1;
   assign req_stall = !core_idle;
   assign out_busy  = rsp_valid_ff && rsp_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lfo_step    <= RST_LFO_STEP;
         cfg_ff.start_phase <= RST_START_PHASE;
         cfg_ff.sweep_depth <= RST_SWEEP_DEPTH;
         cfg_ff.freq_offset <= RST_FREQ_OFFSET;
         cfg_ff.resonance   <= RST_RESONANCE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LFO_STEP:    cfg_ff.lfo_step    <= csr_data;
            CSR_START_PHASE: cfg_ff.start_phase <= csr_data[15:0];
            CSR_SWEEP_DEPTH: cfg_ff.sweep_depth <= csr_data[15:0];
            CSR_FREQ_OFFSET: cfg_ff.freq_offset <= csr_data[15:0];
            CSR_RESONANCE:   cfg_ff.resonance   <= csr_data[11:0];
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   lbw_seq #(
      .UPDATE_INTERVAL(UPDATE_INTERVAL),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .start   (req_valid && !req_stall),
      .sample  (req_sample_in),
      .out_busy(out_busy),
      .idle    (core_idle),
      .done    (core_done),
      .res     (core_res),
      .clip    (core_clip)
   );

   // Output register for the result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_done) begin
         rsp_sample_ff  <= core_res;
         rsp_clipped_ff <= core_clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      core_done |-> !out_busy) else $error("result register overwritten");
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("second sample taken in work");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      core_done |-> !core_idle) else $error("result from an idle core");
`endif

endmodule
